// ===== rtl/bsw_pkg.sv =====
// Shared types and constants for the bounded semaphore wait queue.
// No dependencies; every other file in rtl/ imports this package.
package bsw_pkg;

  // Sizes
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_W        = 8;
  localparam int COUNT_W     = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int TOTAL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // Request codes
  localparam logic [1:0] REQ_SIGNAL  = 2'd0;
  localparam logic [1:0] REQ_WAIT    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  // Event codes
  localparam logic [2:0] EV_GRANTED  = 3'd0;
  localparam logic [2:0] EV_QUEUED   = 3'd1;
  localparam logic [2:0] EV_RAISED   = 3'd2;
  localparam logic [2:0] EV_AT_BOUND = 3'd3;
  localparam logic [2:0] EV_WOKEN    = 3'd4;
  localparam logic [2:0] EV_FULL     = 3'd5;

  // Register indexes (paddr[2])
  localparam logic REG_INIT_COUNT = 1'b0;
  localparam logic REG_COUNT_BOUND = 1'b1;

  // Input and result words
  typedef struct packed {
    logic [1:0]      req_type;
    logic [ID_W-1:0] waiter_id;
  } req_t;

  typedef struct packed {
    logic [2:0]         event_code;
    logic [ID_W-1:0]    woken_id;
    logic [COUNT_W-1:0] count_now;
    logic               last_result;
  } res_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  // Datapath operations
  typedef enum logic [1:0] {
    OP_NONE,
    OP_SIGNAL,
    OP_WAIT,
    OP_DRAIN
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] waiter_id;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic one_left;
  } status_t;

  // Circular pointer advance
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

endpackage

// ===== rtl/bounded_semaphore_wait_queue.sv =====
// Top level of the bounded semaphore wait queue: APB decode, controller, datapath.
// Depends on bsw_pkg, bsw_ctrl and bsw_datapath.
//
//   channel  | handshake                      | word
//   ---------+--------------------------------+-----------------------------
//   request  | start / busy                   | req_i (req_type, waiter_id)
//   result   | result_valid_o, one-cycle pulse| result_o (event, id, count, last)
//   config   | APB psel/penable/pwrite        | pwdata, prdata at paddr 0, 4
//
// Signal and wait results appear the cycle after start is accepted.
// Release-all emits one woken waiter per cycle from the queue head; busy is
// high while every waiter after the first is drained.
// An empty release and request code 3 produce nothing.
// Reset clears count, pointers and fill count; the queue needs no clearing pass.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module bounded_semaphore_wait_queue import bsw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  output logic              result_valid_o,
  output res_t              result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  // APB: zero-wait, write on access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  bsw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .req_i    (req_i),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  bsw_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (paddr[2]),
    .cfg_wdata_i    (pwdata[COUNT_W-1:0]),
    .cfg_rdata_o    (prdata),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== rtl/bsw_ctrl.sv =====
// Controller state machine of the semaphore wait queue.
// Depends on bsw_pkg; drives the datapath with one command per cycle.
module bsw_ctrl import bsw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  req_t    req_i,
  input  status_t status_i,
  output logic    busy,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a release with more than one waiter keeps draining
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_i.req_type == REQ_RELEASE &&
            !status_i.empty && !status_i.one_left) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.one_left) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: command decode
  always_comb begin
    busy            = 1'b0;
    cmd_o.op        = OP_NONE;
    cmd_o.waiter_id = req_i.waiter_id;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            REQ_SIGNAL:  cmd_o.op = OP_SIGNAL;
            REQ_WAIT:    cmd_o.op = OP_WAIT;
            REQ_RELEASE: cmd_o.op = status_i.empty ? OP_NONE : OP_DRAIN;
            default:     cmd_o.op = OP_NONE;
          endcase
        end
      end
      ST_DRAIN: begin
        busy     = 1'b1;
        cmd_o.op = OP_DRAIN;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/bsw_datapath.sv =====
// Datapath: semaphore count, waiter queue, config registers, result register.
// Depends on bsw_pkg; commanded by bsw_ctrl.
module bsw_datapath import bsw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  output logic [APB_DW-1:0]  cfg_rdata_o,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic               result_valid_o,
  output res_t               result_o
);

  logic [COUNT_W-1:0] init_q, bound_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [ID_W-1:0]    store_q [QUEUE_DEPTH];
  logic               store_we;
  logic [ID_W-1:0]    head_id;
  logic               valid_q, valid_d;
  res_t               res_q, res_d;

  assign head_id           = store_q[head_q];
  assign status_o.empty    = (total_q == '0);
  assign status_o.one_left = (total_q == TOTAL_W'(1));

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= '0;
      bound_q <= '1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_INIT_COUNT) init_q <= cfg_wdata_i;
      else bound_q <= cfg_wdata_i;
    end
  end

  assign cfg_rdata_o = (cfg_idx_i == REG_INIT_COUNT) ? APB_DW'(init_q) : APB_DW'(bound_q);

  // Step logic
  always_comb begin
    count_d  = count_q;
    head_d   = head_q;
    tail_d   = tail_q;
    total_d  = total_q;
    store_we = 1'b0;
    valid_d  = 1'b0;
    res_d.event_code  = EV_GRANTED;
    res_d.woken_id    = '0;
    res_d.last_result = 1'b1;
    unique case (cmd_i.op)
      OP_SIGNAL: begin
        valid_d = 1'b1;
        if (total_q != '0) begin
          res_d.event_code = EV_WOKEN;
          res_d.woken_id   = head_id;
          head_d           = next_slot(head_q);
          total_d          = total_q - TOTAL_W'(1);
        end else if (count_q < bound_q) begin
          res_d.event_code = EV_RAISED;
          count_d          = count_q + COUNT_W'(1);
        end else begin
          res_d.event_code = EV_AT_BOUND;
        end
      end
      OP_WAIT: begin
        valid_d = 1'b1;
        if (count_q != '0) begin
          res_d.event_code = EV_GRANTED;
          count_d          = count_q - COUNT_W'(1);
        end else if (total_q < TOTAL_W'(QUEUE_DEPTH)) begin
          res_d.event_code = EV_QUEUED;
          store_we         = 1'b1;
          tail_d           = next_slot(tail_q);
          total_d          = total_q + TOTAL_W'(1);
        end else begin
          res_d.event_code = EV_FULL;
        end
      end
      OP_DRAIN: begin
        valid_d           = 1'b1;
        res_d.event_code  = EV_WOKEN;
        res_d.woken_id    = head_id;
        res_d.last_result = status_o.one_left;
        total_d           = total_q - TOTAL_W'(1);
        // queue emptied: both pointers restart at slot zero
        if (status_o.one_left) begin
          head_d = '0;
          tail_d = '0;
        end else begin
          head_d = next_slot(head_q);
        end
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
    // Writing the initial count reloads the semaphore
    if (cfg_we_i && cfg_idx_i == REG_INIT_COUNT) count_d = cfg_wdata_i;
    res_d.count_now = count_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      total_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      total_q <= total_d;
      valid_q <= valid_d;
    end
  end

  // Waiter store and result word
  always_ff @(posedge clk_i) begin
    if (store_we) store_q[tail_q] <= cmd_i.waiter_id;
    res_q <= res_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

// ===== tb/bsw_tb_pkg.sv =====
// Semaphore shadow for the wait-queue testbench: predicts result words and checks them.
// Depends on bsw_pkg for the word types, event codes and queue depth.
package bsw_tb_pkg;
  import bsw_pkg::*;

  class sem_shadow;
    logic [COUNT_W-1:0] count_q;
    logic [COUNT_W-1:0] bound_q;
    logic [ID_W-1:0]    slot_q [QUEUE_DEPTH];
    int unsigned        head_q;
    int unsigned        tail_q;
    int unsigned        fill_q;
    res_t               due_q [$];
    int                 errors;
    int                 compared;
    int                 seen [6];

    // State as it stands after reset
    function new();
      count_q  = '0;
      bound_q  = '1;
      head_q   = 0;
      tail_q   = 0;
      fill_q   = 0;
      errors   = 0;
      compared = 0;
      foreach (slot_q[i]) slot_q[i] = '0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Loading the initial count overwrites the count; the queue stays as it is
    function void write_reg(logic idx, logic [COUNT_W-1:0] value);
      if (idx == REG_INIT_COUNT) count_q = value;
      else bound_q = value;
    endfunction

    function void push_word(logic [2:0] code, logic [ID_W-1:0] id, logic last);
      res_t w;
      w.event_code  = code;
      w.woken_id    = id;
      w.count_now   = count_q;
      w.last_result = last;
      due_q.push_back(w);
    endfunction

    function logic [ID_W-1:0] pop_head();
      logic [ID_W-1:0] id;
      id     = slot_q[head_q];
      head_q = (head_q + 1) % QUEUE_DEPTH;
      fill_q--;
      return id;
    endfunction

    // Apply one accepted request; returns how many words it will produce
    function int note_request(req_t r);
      int n;
      logic [ID_W-1:0] id;
      n = 0;
      unique case (r.req_type)
        REQ_SIGNAL: begin
          if (fill_q > 0) begin
            id = pop_head();
            push_word(EV_WOKEN, id, 1'b1);
          end else if (count_q < bound_q) begin
            count_q = count_q + 1'b1;
            push_word(EV_RAISED, '0, 1'b1);
          end else begin
            // at the bound, or bound lowered below the count
            push_word(EV_AT_BOUND, '0, 1'b1);
          end
          n = 1;
        end
        REQ_WAIT: begin
          if (count_q != '0) begin
            count_q = count_q - 1'b1;
            push_word(EV_GRANTED, '0, 1'b1);
          end else if (fill_q < QUEUE_DEPTH) begin
            slot_q[tail_q] = r.waiter_id;
            tail_q = (tail_q + 1) % QUEUE_DEPTH;
            fill_q++;
            push_word(EV_QUEUED, '0, 1'b1);
          end else begin
            push_word(EV_FULL, '0, 1'b1);
          end
          n = 1;
        end
        REQ_RELEASE: begin
          // drain in queue order, count untouched; empty queue gives nothing
          while (fill_q > 0) begin
            id = pop_head();
            push_word(EV_WOKEN, id, fill_q == 0);
            n++;
          end
          head_q = 0;
          tail_q = 0;
        end
        default: ;
      endcase
      return n;
    endfunction

    // Compare one result word against the oldest expectation
    function void check_result(res_t got);
      res_t want;
      if (due_q.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      want = due_q.pop_front();
      compared++;
      if (want.event_code <= EV_FULL) seen[want.event_code]++;
      if (got.event_code !== want.event_code) begin
        $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
        errors++;
      end
      if (got.woken_id !== want.woken_id) begin
        $error("woken_id: expected %0d, got %0d", want.woken_id, got.woken_id);
        errors++;
      end
      if (got.count_now !== want.count_now) begin
        $error("count_now: expected %0d, got %0d", want.count_now, got.count_now);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top of the semaphore wait-queue testbench: clock, reset, request and APB drivers.
// Depends on bsw_pkg, bsw_tb_pkg and the bounded_semaphore_wait_queue RTL.
module tb_top;
  import bsw_pkg::*;
  import bsw_tb_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         SETTLE_CYC   = 4;
  localparam int         TAIL_CYC     = 20;
  localparam int         LIMIT_CYC    = 200000;
  localparam int         PHASES       = 4;
  localparam int         PHASE_ITEMS  = 20;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  req_t              req_i = '0;
  logic              result_valid_o;
  res_t              result_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sem_shadow shadow;
  int        cycles = 0;
  int        sent = 0;
  int        reg_writes = 0;

  bounded_semaphore_wait_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycles <= cycles + 1;

  // Result words last one cycle; take each one at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) shadow.check_result(result_o);
  end

  // Watchdog
  initial begin
    wait (cycles >= LIMIT_CYC);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Present one request word; returns at the edge that accepts it, start still high
  task automatic send_req(input logic [1:0] kind, input logic [ID_W-1:0] id,
                          output int words);
    req_t r;
    r.req_type  = kind;
    r.waiter_id = id;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    words = shadow.note_request(r);
    sent++;
  endtask

  // APB write: setup then access phase
  task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow.write_reg(idx, value);
    reg_writes++;
  endtask

  // Drop start, let every expected word arrive, then a few cycles for silent requests
  task automatic settle();
    start <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return COUNT_W'($urandom_range(1, 3));
      2: return '1;
      default: return COUNT_W'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    int done;
    int burst;
    int gap;
    int wait_pct;
    int p;
    logic [1:0]      kind;
    logic [ID_W-1:0] id;

    shadow = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty release, unused code, raise up to a bound of one
    write_reg(REG_COUNT_BOUND, 16'd1);
    write_reg(REG_INIT_COUNT, 16'd0);
    send_req(REQ_RELEASE, 8'h00, n);
    send_req(REQ_UNUSED, 8'hFF, n);
    send_req(REQ_SIGNAL, 8'h00, n);
    send_req(REQ_SIGNAL, 8'h00, n);
    settle();

    // Fill the queue, one wait past full, then wake the head
    write_reg(REG_INIT_COUNT, 16'd0);
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
      id = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : (i == 2) ? 8'h55 :
           (i == 3) ? 8'hAA : ID_W'($urandom);
      send_req(REQ_WAIT, id, n);
    end
    send_req(REQ_SIGNAL, 8'h00, n);
    settle();

    // Full count: release with count nonzero, signal at top, grant, bound below count
    write_reg(REG_COUNT_BOUND, 16'hFFFF);
    write_reg(REG_INIT_COUNT, 16'hFFFF);
    send_req(REQ_RELEASE, 8'h00, n);
    send_req(REQ_SIGNAL, 8'h00, n);
    send_req(REQ_WAIT, 8'h12, n);
    settle();
    write_reg(REG_COUNT_BOUND, 16'd0);
    send_req(REQ_SIGNAL, 8'h00, n);
    settle();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_COUNT_BOUND, 16'hFFFF);
          write_reg(REG_INIT_COUNT, 16'd0);
        end
        1: begin
          write_reg(REG_COUNT_BOUND, 16'd3);
          write_reg(REG_INIT_COUNT, 16'd2);
        end
        default: begin
          write_reg(REG_COUNT_BOUND, pick_count());
          write_reg(REG_INIT_COUNT, pick_count());
        end
      endcase
      wait_pct = $urandom_range(35, 75);
      done = 0;
      while (done < PHASE_ITEMS) begin
        burst = $urandom_range(1, 8);
        for (int k = 0; k < burst && done < PHASE_ITEMS; k++) begin
          p = $urandom_range(0, 99);
          if (p < wait_pct) kind = REQ_WAIT;
          else if (p < 91) kind = REQ_SIGNAL;
          else if (p < 98) kind = REQ_RELEASE;
          else kind = REQ_UNUSED;
          send_req(kind, ID_W'($urandom), n);
          if (n > 0) done++;
        end
        // some bursts run straight into the next one
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      settle();
    end

    repeat (TAIL_CYC) @(posedge clk_i);

    $display("Ran %0d requests across %0d register writes; %0d result words compared.",
             sent, reg_writes, shadow.compared);
    $display("Events: granted %0d, queued %0d, raised %0d, at bound %0d, woken %0d, full %0d",
             shadow.seen[EV_GRANTED], shadow.seen[EV_QUEUED], shadow.seen[EV_RAISED],
             shadow.seen[EV_AT_BOUND], shadow.seen[EV_WOKEN], shadow.seen[EV_FULL]);
    if (shadow.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
